// File: hdl/scs_pkg.sv
// ============================================================================
// scs_pkg - sparse cosine similarity shared definitions
// Item layouts, command codes and the job record between front and back.
// ============================================================================
package scs_pkg;

    localparam int MAX_ENTRIES_DEF = 256;
    localparam int IDX_W           = 20;
    localparam int VAL_W           = 16;
    localparam int SIM_W           = 16;
    localparam int ENTRY_W         = IDX_W + VAL_W;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [1:0] CMD_APPEND_FIRST  = 2'd0;
    localparam logic [1:0] CMD_APPEND_SECOND = 2'd1;
    localparam logic [1:0] CMD_COMPUTE       = 2'd2;

    localparam logic signed [SIM_W-1:0] SIM_MAX = 16'sh7FFF;
    localparam logic signed [SIM_W-1:0] SIM_MIN = 16'sh8000;

    typedef struct packed {
        logic [1:0]              command;
        logic [IDX_W-1:0]        entry_index;
        logic signed [VAL_W-1:0] entry_value;
    } req_t;

    typedef struct packed {
        logic signed [SIM_W-1:0] similarity;
        logic                    size_mismatch;
        logic                    zero_norm;
        logic                    overflowed;
    } rsp_t;

    typedef enum logic [1:0] {
        OP_LOAD_A  = 2'd0,
        OP_LOAD_B  = 2'd1,
        OP_COMPUTE = 2'd2
    } op_t;

    typedef struct packed {
        op_t                     op;
        logic [IDX_W-1:0]        idx;
        logic signed [VAL_W-1:0] val;
    } job_t;

    typedef struct packed {
        logic [IDX_W-1:0]        idx;
        logic signed [VAL_W-1:0] val;
    } entry_t;

endpackage

// File: hdl/scs_ram.sv
// ============================================================================
// scs_ram - generic single write, single read RAM
// One write port, one read port, registered read data.
// ============================================================================
module scs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/scs_front.sv
// ============================================================================
// scs_front - command intake and job queue
// Decodes commands, drops unknown codes, queues jobs for the back end.
// ============================================================================
module scs_front import scs_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic job_valid,
    input  logic job_pop,
    output job_t job
);

    job_t       slot_reg [QUEUE_DEPTH];
    logic [1:0] fill_reg, fill_next;
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic       keep;
    op_t        op;
    logic       push, pop;

    always_comb
    begin
        keep = 1'b1;
        op   = OP_LOAD_A;
        unique case (req.command)
            CMD_APPEND_FIRST:  op = OP_LOAD_A;
            CMD_APPEND_SECOND: op = OP_LOAD_B;
            CMD_COMPUTE:       op = OP_COMPUTE;
            default:           keep = 1'b0;
        endcase
    end

    assign req_stall = (fill_reg == 2'(QUEUE_DEPTH));
    assign push      = req_valid && !req_stall && keep;
    assign pop       = job_pop && job_valid;
    assign job_valid = (fill_reg != 2'd0);
    assign job       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            fill_reg   <= fill_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= '{op: op, idx: req.entry_index, val: req.entry_value};
        end
    end

endmodule

// File: hdl/scs_back.sv
// ============================================================================
// scs_back - vector stores and similarity engine
// Appends entries, runs norm pass, merge walk, square roots and divide.
// ============================================================================
module scs_back import scs_pkg::*; #(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic job_valid,
    output logic job_pop,
    input  job_t job,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int AW     = $clog2(MAX_ENTRIES);
    localparam int CW     = AW + 1;
    localparam int NRM_W  = 2 * VAL_W - 1 + CW;
    localparam int DOT_W  = 2 * VAL_W + CW;
    localparam int RAD_W0 = NRM_W + 20;
    localparam int RAD_W  = RAD_W0 + (RAD_W0 % 2);
    localparam int ROOT_W = RAD_W / 2;
    localparam int QW     = 17;
    localparam int SW     = $clog2(QW);
    localparam int DV_W   = (RAD_W + QW - 1 > DOT_W + 35) ? RAD_W + QW - 1 : DOT_W + 35;

    localparam logic [QW-1:0] Q_NEG_LIM = QW'(32768);
    localparam logic [QW-1:0] Q_POS_LIM = QW'(32767);

    typedef enum logic [9:0] {
        ST_IDLE    = 10'b0000000001,
        ST_NRM_RD  = 10'b0000000010,
        ST_NRM_ACC = 10'b0000000100,
        ST_WLK_RD  = 10'b0000001000,
        ST_WLK_CMP = 10'b0000010000,
        ST_ROOT    = 10'b0000100000,
        ST_MUL     = 10'b0001000000,
        ST_CHK     = 10'b0010000000,
        ST_DIV     = 10'b0100000000,
        ST_DONE    = 10'b1000000000
    } state_t;

    state_t                  state_reg, state_next;
    logic [CW-1:0]           cnt_a_reg, cnt_a_next, cnt_b_reg, cnt_b_next;
    logic                    ovf_reg, ovf_next;
    logic [CW-1:0]           i_reg, i_next, j_reg, j_next;
    logic                    rsp_valid_reg, rsp_valid_next;
    logic                    pass_reg, pass_next;

    logic [NRM_W-1:0]        n1_reg, n1_next, n2_reg, n2_next;
    logic signed [DOT_W-1:0] dot_reg, dot_next;
    logic [RAD_W-1:0]        x_reg, x_next, res_reg, res_next, bit_reg, bit_next;
    logic [ROOT_W-1:0]       s1_reg, s1_next, s2_reg, s2_next;
    logic [RAD_W-1:0]        den_reg, den_next;
    logic [DOT_W-1:0]        mag_reg, mag_next;
    logic                    neg_reg, neg_next;
    logic [DV_W-1:0]         rem_reg, rem_next, dsh_reg, dsh_next;
    logic [QW-1:0]           quo_reg, quo_next;
    logic [SW-1:0]           step_reg, step_next;
    logic                    sat_reg, sat_next;
    logic                    mism_reg, mism_next, zn_reg, zn_next, ovfo_reg, ovfo_next;
    rsp_t                    rsp_reg, rsp_next;

    logic                    we_a, we_b;
    entry_t                  rd_a, rd_b;
    logic signed [2*VAL_W-1:0] sq_a, sq_b, prod;
    logic [RAD_W-1:0]        trial;
    logic signed [SIM_W-1:0] sim;

    scs_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_ENTRIES)) u_ram_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (cnt_a_reg[AW-1:0]),
        .wdata ({job.idx, job.val}),
        .raddr (i_reg[AW-1:0]),
        .rdata (rd_a)
    );

    scs_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_ENTRIES)) u_ram_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (cnt_b_reg[AW-1:0]),
        .wdata ({job.idx, job.val}),
        .raddr (j_reg[AW-1:0]),
        .rdata (rd_b)
    );

    assign sq_a  = rd_a.val * rd_a.val;
    assign sq_b  = rd_b.val * rd_b.val;
    assign prod  = rd_a.val * rd_b.val;
    assign trial = res_reg + bit_reg;

    // saturate quotient to Q1.15 with the sign of the dot product
    always_comb
    begin
        if (neg_reg)
        begin
            sim = (sat_reg || quo_reg >= Q_NEG_LIM) ? SIM_MIN
                                                    : SIM_W'(0) - SIM_W'(quo_reg);
        end
        else
        begin
            sim = (sat_reg || quo_reg >= Q_POS_LIM) ? SIM_MAX : SIM_W'(quo_reg);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_a_next     = cnt_a_reg;
        cnt_b_next     = cnt_b_reg;
        ovf_next       = ovf_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        pass_next      = pass_reg;
        n1_next        = n1_reg;
        n2_next        = n2_reg;
        dot_next       = dot_reg;
        x_next         = x_reg;
        res_next       = res_reg;
        bit_next       = bit_reg;
        s1_next        = s1_reg;
        s2_next        = s2_reg;
        den_next       = den_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        rem_next       = rem_reg;
        dsh_next       = dsh_reg;
        quo_next       = quo_reg;
        step_next      = step_reg;
        sat_next       = sat_reg;
        mism_next      = mism_reg;
        zn_next        = zn_reg;
        ovfo_next      = ovfo_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        we_a           = 1'b0;
        we_b           = 1'b0;
        job_pop        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    job_pop = 1'b1;
                    unique case (job.op)
                        OP_LOAD_A:
                        begin
                            if (cnt_a_reg < CW'(MAX_ENTRIES))
                            begin
                                we_a       = 1'b1;
                                cnt_a_next = cnt_a_reg + 1'b1;
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        OP_LOAD_B:
                        begin
                            if (cnt_b_reg < CW'(MAX_ENTRIES))
                            begin
                                we_b       = 1'b1;
                                cnt_b_next = cnt_b_reg + 1'b1;
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        OP_COMPUTE:
                        begin
                            mism_next = (cnt_a_reg != cnt_b_reg);
                            zn_next   = (cnt_a_reg == cnt_b_reg) && (cnt_a_reg == '0);
                            ovfo_next = ovf_reg;
                            quo_next  = '0;
                            sat_next  = 1'b0;
                            neg_next  = 1'b0;
                            i_next    = '0;
                            j_next    = '0;
                            n1_next   = '0;
                            n2_next   = '0;
                            dot_next  = '0;
                            if (cnt_a_reg != cnt_b_reg || cnt_a_reg == '0)
                            begin
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                state_next = ST_NRM_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_NRM_RD:
            begin
                state_next = ST_NRM_ACC;
            end
            ST_NRM_ACC:
            begin
                n1_next = n1_reg + NRM_W'($unsigned(sq_a));
                n2_next = n2_reg + NRM_W'($unsigned(sq_b));
                if (i_reg + 1'b1 == cnt_a_reg)
                begin
                    i_next     = '0;
                    j_next     = '0;
                    state_next = ST_WLK_RD;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    j_next     = j_reg + 1'b1;
                    state_next = ST_NRM_RD;
                end
            end
            ST_WLK_RD:
            begin
                if (i_reg < cnt_a_reg && j_reg < cnt_b_reg)
                begin
                    state_next = ST_WLK_CMP;
                end
                else if (n1_reg == '0 || n2_reg == '0)
                begin
                    zn_next    = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    x_next     = RAD_W'(n1_reg) << 20;
                    res_next   = '0;
                    bit_next   = RAD_W'(1) << (RAD_W - 2);
                    pass_next  = 1'b0;
                    state_next = ST_ROOT;
                end
            end
            ST_WLK_CMP:
            begin
                if (rd_a.idx < rd_b.idx)
                begin
                    i_next = i_reg + 1'b1;
                end
                else if (rd_a.idx > rd_b.idx)
                begin
                    j_next = j_reg + 1'b1;
                end
                else
                begin
                    dot_next = dot_reg + DOT_W'(prod);
                    i_next   = i_reg + 1'b1;
                    j_next   = j_reg + 1'b1;
                end
                state_next = ST_WLK_RD;
            end
            ST_ROOT:
            begin
                // one bit pair of the digit-by-digit square root per cycle
                if (x_reg >= trial)
                begin
                    x_next   = x_reg - trial;
                    res_next = (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_next = res_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (bit_reg[0])
                begin
                    if (!pass_reg)
                    begin
                        s1_next   = ROOT_W'(res_next);
                        x_next    = RAD_W'(n2_reg) << 20;
                        res_next  = '0;
                        bit_next  = RAD_W'(1) << (RAD_W - 2);
                        pass_next = 1'b1;
                    end
                    else
                    begin
                        s2_next    = ROOT_W'(res_next);
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                den_next   = s1_reg * s2_reg;
                neg_next   = dot_reg[DOT_W-1];
                mag_next   = dot_reg[DOT_W-1] ? DOT_W'(-dot_reg) : DOT_W'(dot_reg);
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                // quotient of 2^17 or more saturates either way
                if ((DV_W'(mag_reg) << (35 - QW)) >= DV_W'(den_reg))
                begin
                    sat_next   = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    rem_next   = DV_W'(mag_reg) << 35;
                    dsh_next   = DV_W'(den_reg) << (QW - 1);
                    quo_next   = '0;
                    step_next  = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (rem_reg >= dsh_reg)
                begin
                    rem_next = rem_reg - dsh_reg;
                    quo_next = {quo_reg[QW-2:0], 1'b1};
                end
                else
                begin
                    quo_next = {quo_reg[QW-2:0], 1'b0};
                end
                dsh_next  = dsh_reg >> 1;
                step_next = step_reg + 1'b1;
                if (step_reg == SW'(QW - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next       = '{similarity: sim, size_mismatch: mism_reg,
                                       zero_norm: zn_reg, overflowed: ovfo_reg};
                    rsp_valid_next = 1'b1;
                    cnt_a_next     = '0;
                    cnt_b_next     = '0;
                    ovf_next       = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_a_reg     <= '0;
            cnt_b_reg     <= '0;
            ovf_reg       <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            pass_reg      <= 1'b0;
            step_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_a_reg     <= cnt_a_next;
            cnt_b_reg     <= cnt_b_next;
            ovf_reg       <= ovf_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            pass_reg      <= pass_next;
            step_reg      <= step_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n1_reg   <= n1_next;
        n2_reg   <= n2_next;
        dot_reg  <= dot_next;
        x_reg    <= x_next;
        res_reg  <= res_next;
        bit_reg  <= bit_next;
        s1_reg   <= s1_next;
        s2_reg   <= s2_next;
        den_reg  <= den_next;
        mag_reg  <= mag_next;
        neg_reg  <= neg_next;
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        quo_reg  <= quo_next;
        sat_reg  <= sat_next;
        mism_reg <= mism_next;
        zn_reg   <= zn_next;
        ovfo_reg <= ovfo_next;
        rsp_reg  <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_a_reg <= CW'(MAX_ENTRIES) && cnt_b_reg <= CW'(MAX_ENTRIES))
        else $error("store count beyond capacity");

    a_mism_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_reg.size_mismatch |->
            rsp_reg.similarity == '0 && !rsp_reg.zero_norm)
        else $error("size mismatch result not forced to zero");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DONE && (!rsp_valid_reg || !rsp_stall) |=>
            cnt_a_reg == '0 && cnt_b_reg == '0 && !ovf_reg && rsp_valid_reg)
        else $error("stores not cleared after result");

    a_walk_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WLK_CMP |-> i_reg < cnt_a_reg && j_reg < cnt_b_reg)
        else $error("merge walk read beyond stored entries");

endmodule

// File: hdl/sparse_cosine_similarity_top.sv
// ============================================================================
// sparse_cosine_similarity_top - sparse vector cosine similarity engine
// Append items are stored by the back end straight from idle; the two-entry job queue
// lets a new item in every cycle while the back end keeps pace.
// Compute runs a norm pass, a merge walk that reads both RAMs before each index
// compare, two digit-by-digit square roots, a multiply, a saturation check, a
// 17-bit long divide and a result stage.
// Async active-low reset empties the queue, zeroes counts, overflow flag and
// result valid; the stores keep stale data, never read past the counts.
// ============================================================================
module sparse_cosine_similarity_top import scs_pkg::*; #(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  logic clk,
    input  logic rst_n,
    // item intake
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    // result items
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    // front decodes and queues, back owns the stores and arithmetic
    logic job_valid;
    logic job_pop;
    job_t job;

    scs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .job_valid (job_valid),
        .job_pop   (job_pop),
        .job       (job)
    );

    // back: norm pass, index merge walk, two roots, one multiply, long divide
    scs_back #(.MAX_ENTRIES(MAX_ENTRIES)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job_pop   (job_pop),
        .job       (job),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule
